// ===== rtl/lmd_pkg.sv =====
package lmd_pkg;

    // ring buffers
    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // sine table, stored as one quarter wave plus the peak entry
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int SINE_QTR   = SINE_DEPTH / 4;
    localparam int SINE_QAW   = $clog2(SINE_QTR + 1);
    localparam int SINE_W     = 15;   // magnitude in Q14, up to 16384

    // datapath widths
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 32;
    localparam int STEP_W   = 19;
    localparam int MIX_W    = 15;
    localparam int PROD_W   = SAMPLE_W + MIX_W + 1;
    localparam int ACC_W    = PROD_W + 2;

    // delay line modulation
    localparam int BASE_DELAY = 960;
    localparam int DELAY_SPAN = 10;
    localparam int DELAY_W    = 10;
    localparam int FILL_W     = 10;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN   = 2'd1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 7;
    localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [SINE_W-1:0] t_sine_rom [SINE_QTR+1];

    typedef struct packed {
        logic [RING_AW-1:0] addr;
        logic               xd_ok;   // input ring entry written since reset
        logic               yd_ok;   // output ring entry written since reset
    } t_rd_req;

    typedef struct packed {
        t_sample sample;
        logic    clip;
    } t_result;

    // quarter-wave sine in Q14, Taylor series to x^15 in Q30, evaluated at elaboration
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        theta;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int v = 0; v <= SINE_QTR; v++) begin
            theta = (HALF_PI_Q30 * 64'(4 * v)) / SINE_DEPTH;
            t2    = (theta * theta) >> 30;
            term  = theta;
            sum   = $signed(theta);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = ((term * t2) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (64'sd1 <<< 30)) begin
                sum = 64'sd1 <<< 30;
            end
            rom[v] = SINE_W'((sum + 64'sd32768) >>> 16);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/lmd_lfo.sv =====
module lmd_lfo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lmd_pkg::STEP_W-1:0]     i_phase_step,
    input  logic                           i_accept,
    input  logic                           i_s2_load,
    output logic [lmd_pkg::RING_AW-1:0]    o_wr_idx,
    output lmd_pkg::t_rd_req               o_rd,
    output logic [lmd_pkg::RING_AW-1:0]    o_wr_next
);

    // running state
    logic [lmd_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [lmd_pkg::RING_AW-1:0] r_wr_idx;
    logic [lmd_pkg::FILL_W-1:0]  r_fill, n_fill;

    // stage 1
    logic [lmd_pkg::SINE_AW-1:0] r_s1_tidx;
    logic [lmd_pkg::RING_AW-1:0] r_s1_widx;
    logic [lmd_pkg::FILL_W-1:0]  r_s1_fill;

    // stage 2
    lmd_pkg::t_rd_req            r_rd, n_rd;
    logic [lmd_pkg::RING_AW-1:0] r_wr_next, n_wr_next;

    logic                            neg;
    logic [lmd_pkg::SINE_AW-1:0]     half_idx;
    logic [lmd_pkg::SINE_AW-1:0]     fold_idx;
    logic [lmd_pkg::SINE_W-1:0]      mag;
    logic signed [lmd_pkg::SINE_W:0] sine;
    logic signed [lmd_pkg::SINE_W+4:0] sine_ext;
    logic signed [lmd_pkg::SINE_W+4:0] prod10;
    logic signed [lmd_pkg::SINE_W+4:0] offset;
    logic [lmd_pkg::DELAY_W-1:0]     delay;

    assign n_phase = r_phase + lmd_pkg::PHASE_W'(i_phase_step);
    assign n_fill  = (r_fill == '1) ? r_fill : r_fill + lmd_pkg::FILL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_wr_idx <= '0;
            r_fill   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_wr_idx <= r_wr_idx + lmd_pkg::RING_AW'(1);
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_tidx <= n_phase[lmd_pkg::PHASE_W-1 -: lmd_pkg::SINE_AW];
            r_s1_widx <= r_wr_idx;
            r_s1_fill <= r_fill;
        end
    end

    // fold the table index into the first quadrant
    always_comb begin
        neg      = r_s1_tidx[lmd_pkg::SINE_AW-1];
        half_idx = {1'b0, r_s1_tidx[lmd_pkg::SINE_AW-2:0]};
        if (half_idx <= lmd_pkg::SINE_AW'(lmd_pkg::SINE_QTR)) begin
            fold_idx = half_idx;
        end else begin
            fold_idx = lmd_pkg::SINE_AW'(lmd_pkg::SINE_DEPTH / 2) - half_idx;
        end
        mag      = lmd_pkg::SINE_ROM[fold_idx[lmd_pkg::SINE_QAW-1:0]];
        sine     = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        sine_ext = (lmd_pkg::SINE_W+5)'(sine);
        prod10   = (sine_ext <<< 3) + (sine_ext <<< 1);
        offset   = prod10 >>> (lmd_pkg::SINE_W - 1);
        delay    = lmd_pkg::DELAY_W'(lmd_pkg::BASE_DELAY) + offset[lmd_pkg::DELAY_W-1:0];

        n_wr_next  = r_s1_widx + lmd_pkg::RING_AW'(1);
        n_rd.addr  = n_wr_next - lmd_pkg::RING_AW'(delay);
        n_rd.xd_ok = ({1'b0, r_s1_fill} + (lmd_pkg::FILL_W+1)'(1)) >= (lmd_pkg::FILL_W+1)'(delay);
        n_rd.yd_ok = r_s1_fill >= lmd_pkg::FILL_W'(delay);
    end

    always_ff @(posedge i_clk) begin
        if (i_s2_load) begin
            r_rd      <= n_rd;
            r_wr_next <= n_wr_next;
        end
    end

    assign o_wr_idx  = r_wr_idx;
    assign o_rd      = r_rd;
    assign o_wr_next = r_wr_next;

    a_delay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s2_load |=>
            ((r_wr_next - r_rd.addr) >= lmd_pkg::RING_AW'(lmd_pkg::BASE_DELAY - lmd_pkg::DELAY_SPAN))
            && ((r_wr_next - r_rd.addr) <= lmd_pkg::RING_AW'(lmd_pkg::BASE_DELAY + lmd_pkg::DELAY_SPAN)))
        else $error("delay tap outside modulation range");

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_fill != '1) |=> r_fill == $past(r_fill) + lmd_pkg::FILL_W'(1))
        else $error("fill count did not advance");

endmodule

// ===== rtl/lmd_ring.sv =====
module lmd_ring (
    input  logic                         i_clk,
    input  logic                         i_in_we,
    input  logic [lmd_pkg::RING_AW-1:0]  i_in_addr,
    input  lmd_pkg::t_sample             i_in_data,
    input  logic                         i_rd_en,
    input  lmd_pkg::t_rd_req             i_rd,
    input  logic                         i_out_we,
    input  logic [lmd_pkg::RING_AW-1:0]  i_out_addr,
    input  lmd_pkg::t_sample             i_out_data,
    output lmd_pkg::t_sample             o_xd,
    output lmd_pkg::t_sample             o_yd
);

    lmd_pkg::t_sample r_in_mem  [lmd_pkg::RING_DEPTH];
    lmd_pkg::t_sample r_out_mem [lmd_pkg::RING_DEPTH];

    lmd_pkg::t_sample r_xd_raw, r_yd_raw;
    logic             r_xd_ok, r_yd_ok;

    always_ff @(posedge i_clk) begin
        if (i_in_we) begin
            r_in_mem[i_in_addr] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_we) begin
            r_out_mem[i_out_addr] <= i_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_xd_raw <= r_in_mem[i_rd.addr];
            r_yd_raw <= r_out_mem[i_rd.addr];
            r_xd_ok  <= i_rd.xd_ok;
            r_yd_ok  <= i_rd.yd_ok;
        end
    end

    // entries not yet written read as zero
    assign o_xd = r_xd_ok ? r_xd_raw : '0;
    assign o_yd = r_yd_ok ? r_yd_raw : '0;

endmodule

// ===== rtl/lmd_mix.sv =====
module lmd_mix (
    input  logic                       i_clk,
    input  logic [lmd_pkg::MIX_W-1:0]  i_mix_gain,
    input  logic                       i_s4_load,
    input  lmd_pkg::t_sample           i_x,
    input  lmd_pkg::t_sample           i_xd,
    input  lmd_pkg::t_sample           i_yd,
    input  logic                       i_out_load,
    output lmd_pkg::t_result           o_ring_data,
    output lmd_pkg::t_result           o_result
);

    logic signed [lmd_pkg::PROD_W-1:0] r_px, r_py;
    lmd_pkg::t_sample                  r_xd;
    lmd_pkg::t_result                  r_result, n_result;

    logic signed [lmd_pkg::MIX_W:0]   gain;
    logic signed [lmd_pkg::ACC_W-1:0] acc;
    logic signed [lmd_pkg::ACC_W-1:0] rnd;
    logic                             ovf_hi, ovf_lo;

    assign gain = $signed({1'b0, i_mix_gain});

    always_ff @(posedge i_clk) begin
        if (i_s4_load) begin
            r_px <= gain * i_x;
            r_py <= gain * i_yd;
            r_xd <= i_xd;
        end
    end

    // Q2.30 sum, round half up to Q1.15, saturate
    always_comb begin
        acc = lmd_pkg::ACC_W'(r_px) + lmd_pkg::ACC_W'(r_py)
            - (lmd_pkg::ACC_W'(r_xd) <<< (lmd_pkg::SAMPLE_W - 1));
        rnd = (acc + (lmd_pkg::ACC_W'(1) <<< (lmd_pkg::SAMPLE_W - 2))) >>> (lmd_pkg::SAMPLE_W - 1);
        ovf_hi = !rnd[lmd_pkg::ACC_W-1] && (|rnd[lmd_pkg::ACC_W-2:lmd_pkg::SAMPLE_W-1]);
        ovf_lo = rnd[lmd_pkg::ACC_W-1] && !(&rnd[lmd_pkg::ACC_W-2:lmd_pkg::SAMPLE_W-1]);
        if (ovf_hi) begin
            n_result.sample = {1'b0, {(lmd_pkg::SAMPLE_W-1){1'b1}}};
        end else if (ovf_lo) begin
            n_result.sample = {1'b1, {(lmd_pkg::SAMPLE_W-1){1'b0}}};
        end else begin
            n_result.sample = rnd[lmd_pkg::SAMPLE_W-1:0];
        end
        n_result.clip = ovf_hi || ovf_lo;
    end

    always_ff @(posedge i_clk) begin
        if (i_out_load) begin
            r_result <= n_result;
        end
    end

    assign o_ring_data = n_result;
    assign o_result    = r_result;

endmodule

// ===== rtl/lfo_modulated_delay_effect.sv =====
// each sample passes the lfo index, tap address, ring read, product and result stages in turn
// throughput: one sample per cycle; the five-stage pipeline only stalls when the
//   result register is full and m_axis_tready is low
// reset: clears the lfo phase, write pointer, fill count, both registers and all
//   stage valid bits; ring memory is not swept, the fill count masks unwritten taps
module lfo_modulated_delay_effect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // input samples
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic signed [15:0]                s_axis_tdata,   // [15:0] sample_in

    // processed samples
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic signed [15:0]                m_axis_tdata,   // [15:0] sample_out
    output logic                              m_axis_tuser,   // [0] clipped

    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lmd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lmd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // configuration registers
    logic [lmd_pkg::STEP_W-1:0] r_phase_step;
    logic [lmd_pkg::MIX_W-1:0]  r_mix_gain;

    // stage valid bits: 1 lfo index, 2 tap address, 3 ring read, 4 products, o result
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic rdy1, rdy2, rdy3, rdy4, rdy_o;
    logic ld1, ld2, ld3, ld4, ld_o;

    // sample and write-pointer pipeline alongside the lfo
    lmd_pkg::t_sample            r_x1, r_x2, r_x3;
    logic [lmd_pkg::RING_AW-1:0] r_wn3, r_wn4;

    logic [lmd_pkg::RING_AW-1:0] wr_idx;
    logic [lmd_pkg::RING_AW-1:0] wr_next;
    lmd_pkg::t_rd_req            rd_req;
    lmd_pkg::t_sample            xd, yd;
    lmd_pkg::t_result            ring_data, result;

    // registers may only be written while idle, so the port never pushes back
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_mix_gain   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lmd_pkg::CFG_PHASE_STEP: begin
                    r_phase_step <= i_cfg_data[lmd_pkg::STEP_W-1:0];
                end
                lmd_pkg::CFG_MIX_GAIN: begin
                    r_mix_gain <= i_cfg_data[lmd_pkg::MIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // each stage takes a new item when it is empty or its own item moves on
    always_comb begin
        rdy_o = !r_vo || m_axis_tready;
        rdy4  = !r_v4 || rdy_o;
        rdy3  = !r_v3 || rdy4;
        rdy2  = !r_v2 || rdy3;
        rdy1  = !r_v1 || rdy2;
        ld1   = s_axis_tvalid && rdy1;
        ld2   = r_v1 && rdy2;
        ld3   = r_v2 && rdy3;
        ld4   = r_v3 && rdy4;
        ld_o  = r_v4 && rdy_o;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy_o) begin
                r_vo <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_x1 <= s_axis_tdata;
        end
        if (ld2) begin
            r_x2 <= r_x1;
        end
        if (ld3) begin
            r_x3  <= r_x2;
            r_wn3 <= wr_next;
        end
        if (ld4) begin
            r_wn4 <= r_wn3;
        end
    end

    // phase accumulator, sine lookup and delay tap address
    lmd_lfo u_lfo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_phase_step (r_phase_step),
        .i_accept     (ld1),
        .i_s2_load    (ld2),
        .o_wr_idx     (wr_idx),
        .o_rd         (rd_req),
        .o_wr_next    (wr_next)
    );

    // dry samples go in on accept, wet samples when the result register loads
    lmd_ring u_ring (
        .i_clk      (i_clk),
        .i_in_we    (ld1),
        .i_in_addr  (wr_idx),
        .i_in_data  (s_axis_tdata),
        .i_rd_en    (ld3),
        .i_rd       (rd_req),
        .i_out_we   (ld_o),
        .i_out_addr (r_wn4),
        .i_out_data (ring_data.sample),
        .o_xd       (xd),
        .o_yd       (yd)
    );

    // mix*x - xd + mix*yd with rounding and saturation
    lmd_mix u_mix (
        .i_clk       (i_clk),
        .i_mix_gain  (r_mix_gain),
        .i_s4_load   (ld4),
        .i_x         (r_x3),
        .i_xd        (xd),
        .i_yd        (yd),
        .i_out_load  (ld_o),
        .o_ring_data (ring_data),
        .o_result    (result)
    );

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = result.sample;
    assign m_axis_tuser  = result.clip;

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v1)
        else $error("accepted item missing from first stage");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_v1 && r_v2 && r_v3 && r_v4 && r_vo)
        else $error("input stalled while pipeline has a bubble");

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata == 16'sh7fff) || (m_axis_tdata == -16'sh8000))
        else $error("clipped result not at a rail");

endmodule

// ===== tb/sv/lfo_modulated_delay_effect_tb.sv =====
`timescale 1ns / 1ps

module lfo_modulated_delay_effect_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int SETTLE_CYCLES = 8;       // idle wait after the pipeline drains
    localparam int MAX_REPORTS  = 50;
    localparam int SWEEP_ITEMS  = 900;      // sweep length; the rings stay short of the shortest tap
    localparam int ROUND_ITEMS  = 40;

    // indexes past the register list, the block must drop these writes
    localparam logic [lmd_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [lmd_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [lmd_pkg::CFG_DATA_W-1:0] DATA_ALL_ONES = '1;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic signed [15:0]             s_axis_tdata = '0;    // [15:0] sample_in
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic signed [15:0]             m_axis_tdata;         // [15:0] sample_out
    logic                           m_axis_tuser;         // [0] clipped
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [lmd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lmd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    lfo_modulated_delay_effect DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // flanger state kept alongside the block
    lmd_pkg::t_sample            dry_hist [lmd_pkg::RING_DEPTH];
    lmd_pkg::t_sample            wet_hist [lmd_pkg::RING_DEPTH];
    logic [lmd_pkg::RING_AW-1:0] wr_ptr;
    logic [lmd_pkg::PHASE_W-1:0] lfo_acc;
    logic [lmd_pkg::PHASE_W-1:0] step_reg;
    int                          mix_reg;
    int                          sine_lut [lmd_pkg::SINE_DEPTH];

    // flanger outputs still owed by the block, oldest first
    lmd_pkg::t_result pending_out [$];

    int  cycle_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  clips_seen = 0;
    int  settings_used = 0;
    int  mismatches = 0;
    bit  quiet = 1'b0;   // set for a stretch with no idling on either side

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_out.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver backpressure, tready low about 7 percent of the time
    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 7);
    end

    // q2.14 sine entry, built from the first quadrant by symmetry
    function automatic int sine_entry(input int unsigned k);
        longint unsigned u;
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        bit              neg;
        int              q;
        u   = 4 * longint'(k);
        neg = 1'b0;
        if (u >= 2 * lmd_pkg::SINE_DEPTH) begin
            neg = 1'b1;
            u   = u - 2 * lmd_pkg::SINE_DEPTH;
        end
        if (u > lmd_pkg::SINE_DEPTH) begin
            u = 2 * lmd_pkg::SINE_DEPTH - u;
        end
        // angle in q30, then taylor series up to x^15, every term truncated
        theta = (QUARTER_TURN_Q30 * u) / lmd_pkg::SINE_DEPTH;
        t2    = (theta * theta) >> 30;
        term  = theta;
        sum   = longint'(theta);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (64'sd1 <<< 30)) begin
            sum = 64'sd1 <<< 30;
        end
        q = int'((sum + 32768) >>> 16);
        return neg ? -q : q;
    endfunction

    // advances the flanger by one sample and gives the output it should produce
    function automatic lmd_pkg::t_result flanger_predict(input lmd_pkg::t_sample x);
        lmd_pkg::t_result            res;
        int                          s;
        int                          delay;
        logic [lmd_pkg::RING_AW-1:0] rd;
        lmd_pkg::t_sample            xd;
        lmd_pkg::t_sample            yd;
        longint                      acc;
        longint                      r;
        lfo_acc = lfo_acc + step_reg;
        // table index is the top bits of the advanced phase
        s     = sine_lut[lfo_acc[lmd_pkg::PHASE_W-1 -: lmd_pkg::SINE_AW]];
        delay = lmd_pkg::BASE_DELAY + ((s * lmd_pkg::DELAY_SPAN) >>> 14);   // floor, 950..970
        dry_hist[wr_ptr] = x;
        wr_ptr = wr_ptr + 1'b1;
        rd = wr_ptr - lmd_pkg::RING_AW'(delay);
        xd = dry_hist[rd];
        yd = wet_hist[rd];
        // q2.30 sum, rounded half up to q1.15, then saturated
        acc = longint'(mix_reg) * longint'(x) + longint'(mix_reg) * longint'(yd)
              - longint'(xd) * 32768;
        r = (acc + 16384) >>> 15;
        res.clip = 1'b0;
        if (r > 32767) begin
            r = 32767;
            res.clip = 1'b1;
        end else if (r < -32768) begin
            r = -32768;
            res.clip = 1'b1;
        end
        res.sample = lmd_pkg::t_sample'(r);
        wet_hist[wr_ptr] = res.sample;
        return res;
    endfunction

    // mostly full scale, with rail values and some quiet material
    function automatic lmd_pkg::t_sample pick_sample();
        lmd_pkg::t_sample v;
        case ($urandom_range(0, 9))
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2: v = lmd_pkg::t_sample'($urandom_range(0, 127)) - 16'sd64;
            3: v = lmd_pkg::t_sample'($urandom_range(24576, 32767));
            4: v = -lmd_pkg::t_sample'($urandom_range(24576, 32767));
            default: v = lmd_pkg::t_sample'($urandom());
        endcase
        return v;
    endfunction

    // one sample over the input stream, now and then with valid dropped first
    task automatic send_sample(input lmd_pkg::t_sample x);
        if (!quiet && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_out.push_back(flanger_predict(x));
        items_sent++;
    endtask

    // stop sending and wait for every owed result, optionally let the pipe settle
    task automatic drain(input bit settle);
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        if (settle) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    // one register write, valid is left high for a following write
    task automatic write_reg(input logic [lmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lmd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lmd_pkg::CFG_PHASE_STEP:
                step_reg = lmd_pkg::PHASE_W'(data[lmd_pkg::STEP_W-1:0]);
            lmd_pkg::CFG_MIX_GAIN:
                mix_reg  = int'(data[lmd_pkg::MIX_W-1:0]);
            default: ;
        endcase
    endtask

    // full register set while idle, with junk writes to unused indexes around it
    task automatic configure(input logic [lmd_pkg::CFG_DATA_W-1:0] step_data,
                             input logic [lmd_pkg::CFG_DATA_W-1:0] mix_data);
        drain(1'b1);
        write_reg(CFG_SPARE_2, lmd_pkg::CFG_DATA_W'($urandom()));
        write_reg(lmd_pkg::CFG_PHASE_STEP, step_data);
        write_reg(CFG_SPARE_3, lmd_pkg::CFG_DATA_W'($urandom()));
        write_reg(lmd_pkg::CFG_MIX_GAIN, mix_data);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // registers at reset: no lfo, no mix, empty rings, so every output is zero
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);
    endtask

    // register extremes, out of range values included, and rail samples
    task automatic test_register_extremes();
        // all data bits set: step at its 19-bit top, mix masked to about 1.0
        configure(DATA_ALL_ONES, DATA_ALL_ONES);
        for (int i = 0; i < 6; i++) begin
            send_sample((i % 2 == 0) ? 16'sh7FFF : 16'sh8000);
        end
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        // frozen lfo, mix at 0.5
        configure('0, lmd_pkg::CFG_DATA_W'(16384));
        send_sample(16'sh4000);
        send_sample(16'shC000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        // top of the nominal step range, dry path muted
        configure(lmd_pkg::CFG_DATA_W'(447392), '0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
    endtask

    // lfo running at top rate while the rings fill; the sweep ends before the
    // shortest tap is reached, so delayed dry and wet samples still read as zero
    task automatic test_lfo_sweep();
        logic [lmd_pkg::CFG_DATA_W-1:0] mix_data;
        // mix of 0.5, with random junk in the data bits above the mix field
        mix_data = lmd_pkg::CFG_DATA_W'(16384);
        mix_data[lmd_pkg::CFG_DATA_W-1:lmd_pkg::MIX_W] = 4'($urandom_range(0, 15) | 8);
        configure(DATA_ALL_ONES, mix_data);
        for (int i = 0; i < SWEEP_ITEMS; i++) begin
            quiet = (i >= 300 && i < 700);
            if (i == 800) begin
                // hold off until the block has caught up completely
                drain(1'b0);
            end
            send_sample(pick_sample());
        end
        quiet = 1'b0;
    endtask

    // several register settings with random traffic in each
    task automatic test_random_settings();
        logic [lmd_pkg::CFG_DATA_W-1:0] step_data;
        logic [lmd_pkg::CFG_DATA_W-1:0] mix_data;
        for (int round = 0; round < 5; round++) begin
            case (round)
                0: begin
                    step_data = '0;
                    mix_data  = '0;
                end
                1: begin
                    // full mix, rails and feedback saturate often
                    step_data = lmd_pkg::CFG_DATA_W'(447392);
                    mix_data  = lmd_pkg::CFG_DATA_W'(32767);
                end
                2: begin
                    step_data = lmd_pkg::CFG_DATA_W'(1);
                    mix_data  = lmd_pkg::CFG_DATA_W'(16384);
                end
                default: begin
                    step_data = lmd_pkg::CFG_DATA_W'($urandom());
                    mix_data  = lmd_pkg::CFG_DATA_W'($urandom());
                end
            endcase
            configure(step_data, mix_data);
            for (int i = 0; i < ROUND_ITEMS; i++) begin
                send_sample(pick_sample());
            end
        end
    endtask

    // result checker, compares against the oldest owed output
    always @(posedge i_clk) begin : check_out
        lmd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_out.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $error("unexpected item: sample_out %0d clipped %0b",
                           m_axis_tdata, m_axis_tuser);
                end
            end else begin
                want = pending_out.pop_front();
                if (want.clip) begin
                    clips_seen++;
                end
                if (m_axis_tdata !== want.sample) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $error("sample_out: expected %0d, got %0d",
                               want.sample, m_axis_tdata);
                    end
                end
                if (m_axis_tuser !== want.clip) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $error("clipped: expected %0b, got %0b",
                               want.clip, m_axis_tuser);
                    end
                end
            end
        end
    end

    initial begin
        // state after reset
        for (int k = 0; k < lmd_pkg::SINE_DEPTH; k++) begin
            sine_lut[k] = sine_entry(k);
        end
        for (int k = 0; k < lmd_pkg::RING_DEPTH; k++) begin
            dry_hist[k] = '0;
            wet_hist[k] = '0;
        end
        wr_ptr   = '0;
        lfo_acc  = '0;
        step_reg = '0;
        mix_reg  = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_lfo_sweep();
        test_random_settings();

        drain(1'b1);
        $display("%0d samples sent through %0d register settings, rings filled past the tap",
                 items_sent, settings_used);
        $display("%0d results checked, %0d saturated, %0d mismatches",
                 results_seen, clips_seen, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
